/* design/gpvc_pkg.sv */
package gpvc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANG_TAB_LEN  = 24;
  localparam int CORD_ITER    = (CORDIC_STEPS < ANG_TAB_LEN) ? CORDIC_STEPS : ANG_TAB_LEN;

  // atan(2^-i) in Q30 radians
  localparam logic [31:0] ANG_TAB [ANG_TAB_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic [31:0]        KINV_Q30    = 32'd652032874;
  localparam logic [31:0]        TWO_LN10_Q20 = 32'd4828871;
  localparam logic [31:0]        RECIP3     = 32'hAAAAAAAB;
  localparam logic [31:0]        ONE_Q30    = 32'h4000_0000;

  localparam logic [1:0] REG_ARRIVAL = 2'd0;
  localparam logic [1:0] REG_MAXADV  = 2'd1;
  localparam logic [1:0] REG_SLOW    = 2'd2;
  localparam logic [1:0] REG_GAIN    = 2'd3;

  localparam logic [11:0] ARRIVAL_RST = 12'd50;
  localparam logic [11:0] MAXADV_RST  = 12'd1000;
  localparam logic [12:0] SLOW_RST    = 13'd500;
  localparam logic [3:0]  GAIN_RST    = 4'd2;

  localparam int DIV_QBITS = 24;

endpackage

/* design/gpvc_in_if.sv */
interface gpvc_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [15:0] target_x;
  logic signed [15:0] target_z;
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_z;
  logic signed [15:0] pose_heading;

  modport source (output valid, action, target_x, target_z, pose_x, pose_z, pose_heading,
                  input ready);
  modport sink   (input valid, action, target_x, target_z, pose_x, pose_z, pose_heading,
                  output ready);
endinterface

/* design/gpvc_out_if.sv */
interface gpvc_out_if;
  logic               valid;
  logic               ready;
  logic        [11:0] speed_advance;
  logic signed [15:0] speed_rotation;
  logic               at_target;

  modport source (output valid, speed_advance, speed_rotation, at_target, input ready);
  modport sink   (input valid, speed_advance, speed_rotation, at_target, output ready);
endinterface

/* design/gpvc_mul.sv */
module gpvc_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p_r
);

  // registered product
  always_ff @(posedge clk) begin
    p_r <= 64'(a) * 64'(b);
  end

endmodule

/* design/gpvc_cordic.sv */
module gpvc_cordic import gpvc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [16:0] dx,
  input  logic signed [16:0] dz,
  output logic               done_r,
  output logic signed [31:0] cx_r,
  output logic signed [33:0] ang_r
);

  logic signed [31:0] cy_r;
  logic signed [31:0] cx_nxt, cy_nxt, sx, sy, ix, iy;
  logic signed [33:0] ang_nxt, tab;
  logic [4:0]         cnt_r;
  logic               busy_r;

  assign ix  = 32'(dz) <<< 12;
  assign iy  = 32'(dx) <<< 12;
  assign sx  = cx_r >>> cnt_r;
  assign sy  = cy_r >>> cnt_r;
  assign tab = $signed({2'b00, ANG_TAB[cnt_r]});

  always_comb begin
    if (cy_r >= 0) begin
      cx_nxt  = cx_r + sy;
      cy_nxt  = cy_r - sx;
      ang_nxt = ang_r + tab;
    end else begin
      cx_nxt  = cx_r - sy;
      cy_nxt  = cy_r + sx;
      ang_nxt = ang_r - tab;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(CORD_ITER - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // pre-rotate the left half plane by a quarter turn, then iterate
  always_ff @(posedge clk) begin
    if (start) begin
      if (ix < 0) begin
        if (iy >= 0) begin
          cx_r  <= iy;
          cy_r  <= -ix;
          ang_r <= HALF_PI_Q30;
        end else begin
          cx_r  <= -iy;
          cy_r  <= ix;
          ang_r <= -HALF_PI_Q30;
        end
      end else begin
        cx_r  <= ix;
        cy_r  <= iy;
        ang_r <= '0;
      end
    end else if (busy_r) begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      ang_r <= ang_nxt;
    end
  end

endmodule

/* design/gpvc_div.sv */
module gpvc_div import gpvc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [36:0] dividend,
  input  logic [12:0] divisor,
  output logic        done_r,
  output logic [23:0] quot_r
);

  logic [12:0] rem_r;
  logic [13:0] trial;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        fit;

  assign trial = {rem_r, quot_r[23]};
  assign fit   = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_QBITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle shifted into the low word
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend[36:24];
      quot_r <= dividend[23:0];
    end else if (busy_r) begin
      rem_r  <= fit ? 13'(trial - {1'b0, divisor}) : trial[12:0];
      quot_r <= {quot_r[22:0], fit};
    end
  end

endmodule

/* design/goto_point_velocity_controller.sv */
// Go-to-goal velocity controller for a differential-drive robot. A word with
// action 0 stores a goal point (mm) and arms it; it yields no result and the
// block is ready again the next cycle. A word with action 1 is a pose tick: with
// no armed goal it yields nothing, otherwise exactly one result word. The goal
// offset goes through a 16-step CORDIC vectoring unit for bearing and distance;
// inside arrival_radius the result is zero speed with at_target set and the
// goal is dropped. Otherwise rotation is gain times bearing in Q3.12, saturated,
// and advance is the speed limit * min(dist/slow_distance, 1) times a Gaussian
// of the rotation, capped at that limit. A tick is finished before the next
// one is taken: 16 CORDIC steps, a chain of products on one shared 32x32
// multiplier (Taylor series and eight squarings) and a bit-serial divider by
// slow_distance that shifts in 24 quotient bits. When the rotation is so large
// that the Gaussian factor is zero, the series and the squarings are skipped.
// in_ch.ready is high only while the sequencer idles; a finished result sits
// in an output register and does not block new input, but the next result
// waits for that register to be taken and holds off input meanwhile.
// Registers sit at byte addresses 0, 4, 8, 12 of the APB port.
module goto_point_velocity_controller import gpvc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  gpvc_in_if.sink     in_ch,
  gpvc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001, S_CORD = 17'h00002, S_DIST = 17'h00004, S_SQ   = 17'h00008,
    S_XM   = 17'h00010, S_XC   = 17'h00020, S_Y2   = 17'h00040, S_Y3   = 17'h00080,
    S_Y4   = 17'h00100, S_D6   = 17'h00200, S_D24  = 17'h00400, S_SQE  = 17'h00800,
    S_NUM  = 17'h01000, S_DIVS = 17'h02000, S_DIVW = 17'h04000, S_ADV  = 17'h08000,
    S_OUT  = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [11:0] arrival_r, maxadv_r;
  logic [12:0] slow_r;
  logic [3:0]  gain_r;

  // goal and per-item working registers
  logic signed [15:0] goal_x_r, goal_z_r, head_r;
  logic               active_r;
  logic [29:0]        dist_r;
  logic signed [21:0] r13_r;
  logic signed [15:0] q12_r;
  logic [25:0]        y_r;
  logic [21:0]        y2_r;
  logic [17:0]        y3_r;
  logic [13:0]        y4_r;
  logic [29:0]        t6_r;
  logic [31:0]        g_r;
  logic [2:0]         sq_cnt_r;

  // result slot
  logic               out_valid_r, res_at_r;
  logic [11:0]        res_adv_r;
  logic signed [15:0] res_rot_r;

  logic               accept, tick, cord_start, cord_done, div_start, div_done;
  logic signed [16:0] dx, dz;
  logic signed [31:0] cx;
  logic signed [33:0] ang;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [23:0]        a12;
  logic [12:0]        sd;
  logic [24:0]        lim, num;
  logic [29:0]        dist_nxt;
  logic signed [35:0] bw, b0;
  logic signed [18:0] b13;
  logic signed [21:0] r13_nxt, q12_wide;
  logic signed [15:0] q12_nxt;
  logic [19:0]        r13_abs;
  logic [25:0]        y_nxt;
  logic [31:0]        e_nxt, e_sq;
  logic [61:0]        e_rnd;
  logic [54:0]        adv_rnd;
  logic [12:0]        adv_w;
  logic               slot_free, wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrival_r <= ARRIVAL_RST;
      maxadv_r  <= MAXADV_RST;
      slow_r    <= SLOW_RST;
      gain_r    <= GAIN_RST;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_ARRIVAL: arrival_r <= pwdata[11:0];
        REG_MAXADV:  maxadv_r  <= pwdata[11:0];
        REG_SLOW:    slow_r    <= pwdata[12:0];
        REG_GAIN:    gain_r    <= pwdata[3:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ARRIVAL: prdata = 32'(arrival_r);
      REG_MAXADV:  prdata = 32'(maxadv_r);
      REG_SLOW:    prdata = 32'(slow_r);
      REG_GAIN:    prdata = 32'(gain_r);
      default:     prdata = '0;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign tick        = accept && in_ch.action && active_r;
  assign cord_start  = tick;
  assign dx          = 17'(goal_x_r) - 17'(in_ch.pose_x);
  assign dz          = 17'(goal_z_r) - 17'(in_ch.pose_z);

  gpvc_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cord_start),
    .dx     (dx),
    .dz     (dz),
    .done_r (cord_done),
    .cx_r   (cx),
    .ang_r  (ang)
  );

  gpvc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  assign sd        = (slow_r == '0) ? 13'd1 : slow_r;
  assign div_start = (state_r == S_DIVS);

  gpvc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod[36:0]),
    .divisor  (sd),
    .done_r   (div_done),
    .quot_r   (a12)
  );

  // bearing: wrap once into [-pi, pi], round to Q13, then scale by gain
  assign dist_nxt = prod[59:30];
  assign b0       = 36'(ang) - (36'(head_r) <<< 17);
  always_comb begin
    bw = b0;
    if (b0 > PI_Q30) bw = b0 - TWO_PI_Q30;
    if (b0 < -PI_Q30) bw = b0 + TWO_PI_Q30;
  end
  assign b13      = 19'((bw + 36'sd65536) >>> 17);
  assign r13_nxt  = $signed({18'd0, gain_r}) * 22'(b13);
  assign q12_wide = (r13_nxt + 22'sd1) >>> 1;
  always_comb begin
    if (q12_wide > 22'sd32767)       q12_nxt = 16'sh7FFF;
    else if (q12_wide < -22'sd32768) q12_nxt = 16'sh8000;
    else                             q12_nxt = q12_wide[15:0];
  end
  assign r13_abs = r13_r[21] ? 20'(-r13_r) : r13_r[19:0];

  // Gaussian series terms
  assign y_nxt   = prod[49:24];
  assign e_nxt   = ONE_Q30 - 32'(y_r) + 32'(y2_r >> 1) - 32'(t6_r) + 32'(prod[63:36]);
  assign e_rnd   = prod[61:0] + 62'(ONE_Q30 >> 1);
  assign e_sq    = 32'(e_rnd[61:30]);

  assign lim     = {sd, 12'd0};
  assign num     = (dist_r < 30'(lim)) ? dist_r[24:0] : lim;
  assign adv_rnd = prod[54:0] + (55'd1 <<< 41);
  assign adv_w   = adv_rnd[54:42];

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_CORD: begin mul_a = cx;                   mul_b = KINV_Q30;      end
      S_SQ:   begin mul_a = 32'(r13_abs);          mul_b = 32'(r13_abs);  end
      S_XM:   begin mul_a = prod[31:0];            mul_b = TWO_LN10_Q20;  end
      S_XC:   begin mul_a = 32'(y_nxt);            mul_b = 32'(y_nxt);    end
      S_Y2:   begin mul_a = 32'(prod[51:30]);      mul_b = 32'(y_r);      end
      S_Y3:   begin mul_a = 32'(prod[47:30]);      mul_b = 32'(y_r);      end
      S_Y4:   begin mul_a = 32'(y3_r);             mul_b = RECIP3;        end
      S_D6:   begin mul_a = 32'(y4_r);             mul_b = RECIP3;        end
      S_D24:  begin mul_a = e_nxt;                 mul_b = e_nxt;         end
      S_SQE:  begin mul_a = e_sq;                  mul_b = e_sq;          end
      S_NUM:  begin mul_a = 32'(maxadv_r);         mul_b = 32'(num);      end
      S_DIVW: begin mul_a = 32'(a12);              mul_b = g_r;           end
      default: ;
    endcase
  end

  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (tick) state_nxt = S_CORD;
      S_CORD: if (cord_done) state_nxt = S_DIST;
      S_DIST: state_nxt = (dist_nxt < {6'd0, arrival_r, 12'd0}) ? S_OUT : S_SQ;
      S_SQ:   state_nxt = S_XM;
      S_XM:   state_nxt = (prod[63:32] != '0) ? S_NUM : S_XC;
      S_XC:   state_nxt = (prod[63:50] != '0) ? S_NUM : S_Y2;
      S_Y2:   state_nxt = S_Y3;
      S_Y3:   state_nxt = S_Y4;
      S_Y4:   state_nxt = S_D6;
      S_D6:   state_nxt = S_D24;
      S_D24:  state_nxt = S_SQE;
      S_SQE:  if (sq_cnt_r == 3'd7) state_nxt = S_NUM;
      S_NUM:  state_nxt = S_DIVS;
      S_DIVS: state_nxt = S_DIVW;
      S_DIVW: if (div_done) state_nxt = S_ADV;
      S_ADV:  state_nxt = S_OUT;
      S_OUT:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && !in_ch.action) active_r <= 1'b1;
      if (state_r == S_DIST && state_nxt == S_OUT) active_r <= 1'b0;
      // hold the result word until taken; load a new one when the slot frees
      if (state_r == S_OUT && slot_free) out_valid_r <= 1'b1;
      else if (out_ch.ready)             out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && !in_ch.action) begin
      goal_x_r <= in_ch.target_x;
      goal_z_r <= in_ch.target_z;
    end
    if (accept) head_r <= in_ch.pose_heading;
    unique case (state_r)
      S_DIST: begin
        dist_r    <= dist_nxt;
        r13_r     <= r13_nxt;
        q12_r     <= q12_nxt;
        res_adv_r <= '0;
        res_rot_r <= '0;
        res_at_r  <= 1'b1;
      end
      S_XM:   if (prod[63:32] != '0) g_r <= '0;
      S_XC: begin
        if (prod[63:50] != '0) g_r <= '0;
        y_r <= y_nxt;
      end
      S_Y2:   y2_r <= prod[51:30];
      S_Y3:   y3_r <= prod[47:30];
      S_Y4:   y4_r <= prod[43:30];
      S_D6:   t6_r <= prod[63:34];
      S_D24:  sq_cnt_r <= '0;
      S_SQE: begin
        sq_cnt_r <= sq_cnt_r + 3'd1;
        if (sq_cnt_r == 3'd7) g_r <= e_sq;
      end
      S_ADV: begin
        res_adv_r <= (adv_w > {1'b0, maxadv_r}) ? maxadv_r : adv_w[11:0];
        res_rot_r <= q12_r;
        res_at_r  <= 1'b0;
      end
      default: ;
    endcase
  end

  logic [11:0]        o_adv_r;
  logic signed [15:0] o_rot_r;
  logic               o_at_r;

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && slot_free) begin
      o_adv_r <= res_adv_r;
      o_rot_r <= res_rot_r;
      o_at_r  <= res_at_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.speed_advance  = o_adv_r;
  assign out_ch.speed_rotation = o_rot_r;
  assign out_ch.at_target      = o_at_r;

endmodule

/* tb/sv/gpvc_scoreboard.sv */
module gpvc_scoreboard import gpvc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  gpvc_in_if   in_mon,
  gpvc_out_if  out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          err_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [11:0]        advance;
    logic signed [15:0] rotation;
    logic               arrived;
  } speed_cmd_t;

  speed_cmd_t cmd_q[$];

  logic [11:0] radius_mm, adv_max;
  logic [12:0] slow_mm;
  logic [3:0]  gain;
  longint      goal_x, goal_z;
  bit          goal_armed;

  function automatic longint gauss_factor(longint r13);
    longint x, y, y2, y3, y4, e;
    x = (r13 * r13 * longint'(TWO_LN10_Q20)) >>> 16;
    if (x >= (longint'(16) <<< 30)) return 0;
    y  = x >>> 8;
    y2 = (y * y) >>> 30;
    y3 = (y2 * y) >>> 30;
    y4 = (y3 * y) >>> 30;
    e  = longint'(ONE_Q30) - y + y2 / 2 - y3 / 6 + y4 / 24;
    for (int i = 0; i < 8; i++) e = (e * e + (longint'(1) <<< 29)) >>> 30;
    return e;
  endfunction

  // Advance the goal state for one word; return 1 when a command word follows.
  function automatic bit steer(input logic act, input logic signed [15:0] tx, tz,
                               input logic signed [15:0] px, pz, hd,
                               output speed_cmd_t cmd);
    longint cx, cy, ang, t, nx, ny, range_q12, b, b13, r13, q12, g, sd, num, a12, adv;
    cmd = '{default: '0};
    if (!act) begin
      goal_x = tx;
      goal_z = tz;
      goal_armed = 1;
      return 0;
    end
    if (!goal_armed) return 0;
    cy = (goal_x - longint'(px)) * 4096;
    cx = (goal_z - longint'(pz)) * 4096;
    ang = 0;
    if (cx < 0) begin
      t = cx;
      if (cy >= 0) begin
        cx = cy; cy = -t; ang = longint'(HALF_PI_Q30);
      end else begin
        cx = -cy; cy = t; ang = -longint'(HALF_PI_Q30);
      end
    end
    for (int i = 0; i < CORD_ITER; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i); ny = cy - (cx >>> i); ang += longint'(ANG_TAB[i]);
      end else begin
        nx = cx - (cy >>> i); ny = cy + (cx >>> i); ang -= longint'(ANG_TAB[i]);
      end
      cx = nx; cy = ny;
    end
    range_q12 = (cx * longint'(KINV_Q30)) >>> 30;
    if (range_q12 < (longint'(radius_mm) <<< 12)) begin
      goal_armed = 0;
      cmd.arrived = 1;
      return 1;
    end
    b = ang - longint'(hd) * 131072;
    if (b > longint'(PI_Q30)) b -= longint'(TWO_PI_Q30);
    if (b < -longint'(PI_Q30)) b += longint'(TWO_PI_Q30);
    b13 = (b + 65536) >>> 17;
    r13 = longint'(gain) * b13;
    q12 = (r13 + 1) >>> 1;
    if (q12 > 32767) q12 = 32767;
    if (q12 < -32768) q12 = -32768;
    g   = gauss_factor(r13);
    sd  = (slow_mm != 0) ? longint'(slow_mm) : 1;
    num = (range_q12 < (sd <<< 12)) ? range_q12 : (sd <<< 12);
    a12 = (longint'(adv_max) * num) / sd;
    adv = (a12 * g + (longint'(1) <<< 41)) >>> 42;
    if (adv > longint'(adv_max)) adv = adv_max;
    cmd.advance  = adv[11:0];
    cmd.rotation = q12[15:0];
    return 1;
  endfunction

  always @(posedge clk) begin
    speed_cmd_t c, want;
    if (!rst_n) begin
      radius_mm <= ARRIVAL_RST;
      adv_max   <= MAXADV_RST;
      slow_mm   <= SLOW_RST;
      gain      <= GAIN_RST;
      goal_armed = 0;
      goal_x = 0;
      goal_z = 0;
      cmd_q.delete();
      err_count <= 0;
      checked   <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (steer(in_mon.action, in_mon.target_x, in_mon.target_z, in_mon.pose_x,
                  in_mon.pose_z, in_mon.pose_heading, c))
          cmd_q.push_back(c);
      end
      if (out_mon.valid && out_mon.ready) begin
        checked <= checked + 1;
        if (cmd_q.size() == 0) begin
          $error("result word with nothing expected");
          err_count <= err_count + 1;
        end else begin
          want = cmd_q.pop_front();
          if (out_mon.speed_advance !== want.advance ||
              out_mon.speed_rotation !== want.rotation ||
              out_mon.at_target !== want.arrived)
            err_count <= err_count + 1;
          if (out_mon.speed_advance !== want.advance)
            $error("speed_advance expected %0d got %0d", want.advance, out_mon.speed_advance);
          if (out_mon.speed_rotation !== want.rotation)
            $error("speed_rotation expected %0d got %0d", want.rotation,
                   out_mon.speed_rotation);
          if (out_mon.at_target !== want.arrived)
            $error("at_target expected %0d got %0d", want.arrived, out_mon.at_target);
        end
      end
      // Mirror register writes; the block applies them at the same edge.
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ARRIVAL: radius_mm <= pwdata[11:0];
          REG_MAXADV:  adv_max   <= pwdata[11:0];
          REG_SLOW:    slow_mm   <= pwdata[12:0];
          REG_GAIN:    gain      <= pwdata[3:0];
          default: ;
        endcase
      end
    end
    pending = cmd_q.size();
  end

endmodule

/* tb/sv/testbench.sv */
module testbench import gpvc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          err_count, pending, checked;
  int          words_sent = 0;
  bit          burst_mode = 0;   // no idling on either side while set
  bit          hold_req = 0;     // ask the receiver for one long hold-off

  gpvc_in_if  in_ch();
  gpvc_out_if out_ch();

  goto_point_velocity_controller DUT (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  gpvc_scoreboard u_score (
    .clk, .rst_n, .in_mon(in_ch), .out_mon(out_ch),
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .err_count, .pending, .checked
  );

  always #5 clk = ~clk;

  // Drive every input to a known value before the first edge.
  initial begin
    in_ch.valid = 0;
    in_ch.action = 0;
    in_ch.target_x = 0;
    in_ch.target_z = 0;
    in_ch.pose_x = 0;
    in_ch.pose_z = 0;
    in_ch.pose_heading = 0;
    out_ch.ready = 0;
  end

  // Receiver: draw a wait per word, hold ready low, then take the next word.
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, 13);
      if (hold_req) begin
        hold_req = 0;
        gap = 3000;     // long stall so the block backs up into its input
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ch.ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Send one word; returns at the accepting edge with valid still high.
  task automatic send_word(input logic act, input logic signed [15:0] tx, tz,
                           input logic signed [15:0] px, pz, hd);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1;
    in_ch.action = act;
    in_ch.target_x = tx;
    in_ch.target_z = tz;
    in_ch.pose_x = px;
    in_ch.pose_z = pz;
    in_ch.pose_heading = hd;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic set_goal(input logic signed [15:0] x, z);
    send_word(1'b0, x, z, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic pose_tick(input logic signed [15:0] x, z, hd);
    send_word(1'b1, 16'($urandom), 16'($urandom), x, z, hd);
  endtask

  function automatic logic signed [15:0] rand_heading();
    return 16'($signed($urandom_range(0, 51472)) - 25736);
  endfunction

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return 16'(v);
  endfunction

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  // Drain results, then let a tick with no result run out before a write.
  task automatic settle();
    @(negedge clk);
    in_ch.valid = 0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic program_regs(input int rad, adv, slow, g);
    settle();
    reg_write(REG_ARRIVAL, 32'(rad) | 32'hFFFF_F000 & 32'($urandom));
    reg_write(REG_MAXADV, 32'(adv));
    reg_write(REG_SLOW, 32'(slow));
    reg_write(REG_GAIN, 32'(g));
  endtask

  // Random traffic: mostly a goal followed by a run of ticks closing in on it.
  task automatic random_traffic(input int n_words);
    int sent, steps, span, gx, gz, full;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any word at all
        if ($urandom_range(0, 1))
          set_goal(16'($urandom), 16'($urandom));
        else
          pose_tick(16'($urandom), 16'($urandom), rand_heading());
        sent++;
      end else begin
        full = ($urandom_range(0, 3) == 0);
        gx = full ? $signed(16'($urandom)) : $signed($urandom_range(0, 8000)) - 4000;
        gz = full ? $signed(16'($urandom)) : $signed($urandom_range(0, 8000)) - 4000;
        set_goal(16'(gx), 16'(gz));
        sent++;
        steps = $urandom_range(1, 8);
        span = full ? 65535 : 4000;
        for (int k = 0; k < steps; k++) begin
          pose_tick(clip16(gx + $urandom_range(0, 2 * span) - span),
                    clip16(gz + $urandom_range(0, 2 * span) - span), rand_heading());
          sent++;
          if (span > 8) span = span / 3;
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset settings, three quadrants, axis offsets, field extremes, arrival.
    pose_tick(16'sd100, 16'sd100, 16'sd0);          // no goal: no word out
    set_goal(16'sd32767, 16'sd32767);
    pose_tick(-16'sd32768, -16'sd32768, 16'sd25736);
    pose_tick(-16'sd32768, 16'sd32767, -16'sd25736);
    pose_tick(16'sd32767, -16'sd32768, 16'sd0);
    set_goal(-16'sd32768, -16'sd32768);
    pose_tick(16'sd32767, 16'sd32767, 16'sd0);
    set_goal(16'sd0, 16'sd0);
    pose_tick(16'sd0, -16'sd600, 16'sd0);
    pose_tick(16'sd0, 16'sd600, 16'sd0);
    pose_tick(16'sd300, 16'sd300, 16'sd1000);
    pose_tick(-16'sd300, 16'sd300, -16'sd1000);
    pose_tick(16'sd10, 16'sd10, 16'sd0);            // arrival drops the goal
    pose_tick(16'sd10, 16'sd10, 16'sd0);            // no goal after arrival
    set_goal(16'sd5, 16'sd5);
    set_goal(16'sd2000, -16'sd2000);                // replaces the goal
    pose_tick(16'sd0, 16'sd0, 16'sd25736);

    // Zero radius never arrives; zero offset; slow distance 0 acts as 1 mm.
    program_regs(0, 4095, 0, 15);
    set_goal(16'sd5, 16'sd5);
    pose_tick(16'sd5, 16'sd5, 16'sd1000);
    pose_tick(16'sd5, 16'sd5, -16'sd25736);
    pose_tick(16'sd6, 16'sd5, 16'sd0);

    random_traffic(250);

    program_regs(4095, 0, 8191, 0);
    random_traffic(200);

    // Back-pressure phase with a long receiver stall.
    program_regs(50, 1000, 500, 2);
    hold_req = 1;
    random_traffic(300);

    program_regs(200, 4095, 1, 1);
    burst_mode = 1;
    random_traffic(200);
    burst_mode = 0;

    program_regs($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(1, 8191), $urandom_range(0, 15));
    random_traffic(300);

    program_regs(10, 4095, 8191, 15);
    random_traffic(250);

    settle();
    repeat (100) @(posedge clk);
    $display("Sent %0d input words over seven register settings, with stalls and bursts;",
             words_sent);
    $display("checked %0d result words against the prediction.", checked);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
design/gpvc_pkg.sv
design/gpvc_in_if.sv
design/gpvc_out_if.sv
design/gpvc_mul.sv
design/gpvc_cordic.sv
design/gpvc_div.sv
design/goto_point_velocity_controller.sv
tb/sv/gpvc_scoreboard.sv
tb/sv/testbench.sv
